// ===== rtl/tzse_pkg.sv =====
// Package: shared types and constants for the zero-suppression encoder.
`default_nettype none
package tzse_pkg;

  localparam int unsigned SampleW   = 15;
  localparam int unsigned WordW     = 16;
  localparam int unsigned RunW      = 14;
  localparam int unsigned OffsetW   = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MaxSamples = 4096;

  localparam logic [SampleW-1:0] WindowLowReset  = 15'h0041;
  localparam logic [SampleW-1:0] WindowHighReset = 15'h03bf;

  localparam logic [CfgIdxW-1:0] RegWindowLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWindowHigh = 2'd1;

  // One queued work unit: up to two result words (skip word, then sample).
  typedef struct packed {
    logic               has_skip;
    logic [RunW-1:0]    skip_count;
    logic               has_sample;
    logic [SampleW-1:0] sample;
    logic               window_end;
    logic               trig_found;
    logic [OffsetW-1:0] trig_offset;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

// ===== rtl/tzse_front.sv =====
// Front end: config registers, sample classification and window state.
`default_nettype none
module tzse_front #(
  parameter int unsigned MAX_SAMPLES = tzse_pkg::MaxSamples
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tzse_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tzse_pkg::SampleW-1:0]  cfg_wdata_i,
  input  wire logic                          in_fire_i,
  input  wire logic [tzse_pkg::SampleW-1:0]  sample_i,
  input  wire logic                          window_last_i,
  output logic                               push_o,
  output tzse_pkg::entry_t                   entry_o
);

  localparam int unsigned PosW = $clog2(MAX_SAMPLES);
  localparam int unsigned ExtW = (PosW > tzse_pkg::OffsetW) ? PosW : tzse_pkg::OffsetW;
  localparam logic [PosW-1:0] PosLast = PosW'(MAX_SAMPLES - 1);

  logic [tzse_pkg::SampleW-1:0] window_low_q, window_high_q;
  logic                         run_pending_q, run_pending_d;
  logic [tzse_pkg::RunW-1:0]    run_count_q, run_count_d;
  logic                         triggered_q, triggered_d;
  logic [tzse_pkg::OffsetW-1:0] first_offset_q, first_offset_d;
  logic [PosW-1:0]              position_q, position_d;

  logic                         keep;
  logic                         trig_now;
  logic [ExtW-1:0]              pos_ext;
  logic [tzse_pkg::OffsetW-1:0] pos_off;
  logic [tzse_pkg::OffsetW-1:0] off_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_low_q  <= tzse_pkg::WindowLowReset;
      window_high_q <= tzse_pkg::WindowHighReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tzse_pkg::RegWindowLow:  window_low_q  <= cfg_wdata_i;
        tzse_pkg::RegWindowHigh: window_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign keep     = (sample_i < window_low_q) || (sample_i > window_high_q);
  assign trig_now = triggered_q | keep;
  assign pos_ext  = ExtW'(position_q);
  assign pos_off  = pos_ext[tzse_pkg::OffsetW-1:0];
  assign off_now  = triggered_q ? first_offset_q : (keep ? pos_off : '0);

  always_comb begin
    entry_o.has_skip    = keep & run_pending_q;
    entry_o.skip_count  = run_count_q;
    entry_o.has_sample  = keep;
    entry_o.sample      = sample_i;
    entry_o.window_end  = window_last_i;
    entry_o.trig_found  = trig_now;
    entry_o.trig_offset = off_now;
  end

  assign push_o = in_fire_i & (keep | window_last_i);

  always_comb begin
    run_pending_d  = run_pending_q;
    run_count_d    = run_count_q;
    triggered_d    = triggered_q;
    first_offset_d = first_offset_q;
    position_d     = position_q;
    if (in_fire_i) begin
      if (window_last_i) begin
        run_pending_d  = 1'b0;
        run_count_d    = '0;
        triggered_d    = 1'b0;
        first_offset_d = '0;
        position_d     = '0;
      end else begin
        position_d = (position_q == PosLast) ? '0 : position_q + 1'b1;
        if (keep) begin
          triggered_d    = 1'b1;
          first_offset_d = off_now;
          run_pending_d  = 1'b0;
          run_count_d    = '0;
        end else if (triggered_q) begin
          if (run_pending_q) begin
            run_count_d = run_count_q + 1'b1; // wraps at 14 bits
          end else begin
            run_pending_d = 1'b1;
            run_count_d   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_pending_q  <= 1'b0;
      run_count_q    <= '0;
      triggered_q    <= 1'b0;
      first_offset_q <= '0;
      position_q     <= '0;
    end else begin
      run_pending_q  <= run_pending_d;
      run_count_q    <= run_count_d;
      triggered_q    <= triggered_d;
      first_offset_q <= first_offset_d;
      position_q     <= position_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tzse_queue.sv =====
// Two-entry queue between the front and back ends.
`default_nettype none
module tzse_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire tzse_pkg::entry_t    entry_i,
  input  wire logic                pop_i,
  output tzse_pkg::entry_t         head_o,
  output tzse_pkg::queue_status_t  status_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tzse_pkg::entry_t  mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tzse_back.sv =====
// Back end: expands queued entries into result words, registered output.
`default_nettype none
module tzse_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tzse_pkg::entry_t              head_i,
  input  wire tzse_pkg::queue_status_t       status_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [tzse_pkg::WordW-1:0]         word_o,
  output logic                               word_valid_o,
  output logic                               window_end_o,
  output logic                               trigger_found_o,
  output logic [tzse_pkg::OffsetW-1:0]       trigger_offset_o,
  output logic                               last_o
);

  logic                         out_valid_q, out_valid_d;
  logic [tzse_pkg::WordW-1:0]   word_q, word_d;
  logic                         word_valid_q, word_valid_d;
  logic                         window_end_q, window_end_d;
  logic                         trig_found_q, trig_found_d;
  logic [tzse_pkg::OffsetW-1:0] trig_offset_q, trig_offset_d;
  logic                         last_q, last_d;
  logic                         phase_q, phase_d; // skip word of head already sent
  logic                         load, emit_skip;

  assign load      = ~status_i.empty & (~out_valid_q | out_ready_i);
  assign emit_skip = head_i.has_skip & ~phase_q;
  assign pop_o     = load & ~emit_skip;

  always_comb begin
    out_valid_d   = out_valid_q & ~out_ready_i;
    word_d        = word_q;
    word_valid_d  = word_valid_q;
    window_end_d  = window_end_q;
    trig_found_d  = trig_found_q;
    trig_offset_d = trig_offset_q;
    last_d        = last_q;
    phase_d       = phase_q;
    if (load) begin
      out_valid_d   = 1'b1;
      trig_found_d  = head_i.trig_found;
      trig_offset_d = head_i.trig_offset;
      if (emit_skip) begin
        word_d       = {1'b1, 1'b0, head_i.skip_count};
        word_valid_d = 1'b1;
        window_end_d = 1'b0;
        last_d       = 1'b0;
        phase_d      = 1'b1;
      end else begin
        word_d       = head_i.has_sample ? {1'b0, head_i.sample} : '0;
        word_valid_d = head_i.has_sample;
        window_end_d = head_i.window_end;
        last_d       = 1'b1;
        phase_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q        <= word_d;
    word_valid_q  <= word_valid_d;
    window_end_q  <= window_end_d;
    trig_found_q  <= trig_found_d;
    trig_offset_q <= trig_offset_d;
    last_q        <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign word_o           = word_q;
  assign word_valid_o     = word_valid_q;
  assign window_end_o     = window_end_q;
  assign trigger_found_o  = trig_found_q;
  assign trigger_offset_o = trig_offset_q;
  assign last_o           = last_q;

endmodule
`default_nettype wire

// ===== rtl/threshold_zero_suppression_encoder_core.sv =====
// With output idle, a sample's first word goes via a queue entry, then the output register.
// Throughput: one sample per cycle; a sample that emits a skip word plus itself
// holds the back end for both words, which can fill the two-entry queue.
// The input stalls only while that queue is full; front state is registered on each accept.
// Reset (async, active low) clears window state, queue and output; thresholds go to 65/959.
`default_nettype none
module threshold_zero_suppression_encoder_core #(
  parameter int unsigned MAX_SAMPLES = tzse_pkg::MaxSamples
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tzse_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tzse_pkg::SampleW-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [tzse_pkg::SampleW-1:0]  sample_i,
  input  wire logic                          window_last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [tzse_pkg::WordW-1:0]         word_o,
  output logic                               word_valid_o,
  output logic                               window_end_o,
  output logic                               trigger_found_o,
  output logic [tzse_pkg::OffsetW-1:0]       trigger_offset_o,
  output logic                               last_o
);

  tzse_pkg::entry_t        push_entry, head;
  tzse_pkg::queue_status_t status;
  logic                    push, pop, in_fire;

  assign in_ready_o = ~status.full;
  assign in_fire    = in_valid_i & in_ready_o;

  tzse_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_fire_i     (in_fire),
    .sample_i      (sample_i),
    .window_last_i (window_last_i),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  tzse_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  tzse_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .status_i         (status),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .word_o           (word_o),
    .word_valid_o     (word_valid_o),
    .window_end_o     (window_end_o),
    .trigger_found_o  (trigger_found_o),
    .trigger_offset_o (trigger_offset_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

// ===== tb/tzse_checker.sv =====
// Checker: watches both channels of the encoder, predicts each result word and compares.
module tzse_checker
  import tzse_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [SampleW-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [SampleW-1:0] sample_i,
  input  wire logic               window_last_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [WordW-1:0]   word_i,
  input  wire logic               word_valid_i,
  input  wire logic               window_end_i,
  input  wire logic               trigger_found_i,
  input  wire logic [OffsetW-1:0] trigger_offset_i,
  input  wire logic               last_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WordW-1:0]   word;
    logic               word_valid;
    logic               window_end;
    logic               trig_found;
    logic [OffsetW-1:0] trig_offset;
    logic               last;
  } enc_word_t;

  enc_word_t expected_words_q[$];
  enc_word_t seen_word;
  enc_word_t want_word;
  int unsigned errors = 0;

  // predictor copy of the thresholds and the window state
  logic [SampleW-1:0] band_low;
  logic [SampleW-1:0] band_high;
  logic               run_open;
  logic [RunW-1:0]    run_len_m1;
  logic               armed;
  logic [OffsetW-1:0] first_kept;
  logic [OffsetW-1:0] sample_pos;

  task automatic encode_sample(input logic [SampleW-1:0] s, input logic closing);
    logic             keep;
    logic [WordW-1:0] words [2];
    int               n;
    logic             fin;
    keep = (s < band_low) || (s > band_high);
    n = 0;
    if (keep) begin
      if (!armed) begin
        armed = 1'b1;
        first_kept = sample_pos;
      end
      if (run_open) begin
        words[n] = {1'b1, 1'b0, run_len_m1};
        n++;
        run_open = 1'b0;
        run_len_m1 = '0;
      end
      words[n] = {1'b0, s};
      n++;
    end else if (armed) begin
      if (run_open) begin
        run_len_m1 = run_len_m1 + 1'b1;
      end else begin
        run_open = 1'b1;
        run_len_m1 = '0;
      end
    end
    if (n == 0) begin
      if (closing) begin
        expected_words_q.push_back({{WordW{1'b0}}, 1'b0, 1'b1, armed,
                                    armed ? first_kept : {OffsetW{1'b0}}, 1'b1});
      end
    end else begin
      for (int k = 0; k < n; k++) begin
        fin = (k == n - 1);
        expected_words_q.push_back({words[k], 1'b1, fin & closing, armed,
                                    first_kept, fin});
      end
    end
    // trailing run is dropped with the rest of the window
    if (closing) begin
      run_open = 1'b0;
      run_len_m1 = '0;
      armed = 1'b0;
      first_kept = '0;
      sample_pos = '0;
    end else begin
      sample_pos = sample_pos + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_words_q.delete();
      band_low = WindowLowReset;
      band_high = WindowHighReset;
      run_open = 1'b0;
      run_len_m1 = '0;
      armed = 1'b0;
      first_kept = '0;
      sample_pos = '0;
      pending_o <= 0;
      fail_count_o <= errors;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen_word = {word_i, word_valid_i, window_end_i, trigger_found_i,
                     trigger_offset_i, last_i};
        if (expected_words_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual word=%h wv=%b end=%b trig=%b off=%0d last=%b",
                   $time, word_i, word_valid_i, window_end_i, trigger_found_i,
                   trigger_offset_i, last_i);
        end else begin
          want_word = expected_words_q.pop_front();
          if (seen_word !== want_word) begin
            errors++;
            $display("%0t: word mismatch: expected word=%h wv=%b end=%b trig=%b off=%0d last=%b",
                     $time, want_word.word, want_word.word_valid, want_word.window_end,
                     want_word.trig_found, want_word.trig_offset, want_word.last);
            $display("%0t:                actual   word=%h wv=%b end=%b trig=%b off=%0d last=%b",
                     $time, seen_word.word, seen_word.word_valid, seen_word.window_end,
                     seen_word.trig_found, seen_word.trig_offset, seen_word.last);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegWindowLow: begin
            band_low = cfg_wdata_i;
          end
          RegWindowHigh: begin
            band_high = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        encode_sample(sample_i, window_last_i);
      end
      pending_o <= expected_words_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ===== tb/tb_threshold_zero_suppression_encoder_core.sv =====
// Testbench top: drives samples and threshold writes into the encoder and gives the verdict.
module tb_threshold_zero_suppression_encoder_core;
  import tzse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;
  localparam int unsigned        StallLimit = 5000;
  localparam int                 SampleMax = 32767;
  localparam int                 PhaseItems = 200;

  typedef enum logic [1:0] {RxOpen, RxCoin, RxPeriodic, RxSparse} rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [SampleW-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [SampleW-1:0] sample_i = '0;
  logic               window_last_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [WordW-1:0]   word_o;
  logic               word_valid_o;
  logic               window_end_o;
  logic               trigger_found_o;
  logic [OffsetW-1:0] trigger_offset_o;
  logic               last_o;

  int unsigned fail_count;
  int unsigned pending_words;

  // current thresholds as seen by the stimulus, for picking in/out-of-band samples
  int band_lo = 65;
  int band_hi = 959;
  bit idle_on = 1'b0;
  int burst_left = 0;

  rx_mode_e    rx_mode = RxOpen;
  int          rx_hold = 0;
  logic [2:0]  rx_tick = '0;
  int unsigned stall_cycles = 0;

  threshold_zero_suppression_encoder_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .window_last_i    (window_last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .word_o           (word_o),
    .word_valid_o     (word_valid_o),
    .window_end_o     (window_end_o),
    .trigger_found_o  (trigger_found_o),
    .trigger_offset_o (trigger_offset_o),
    .last_o           (last_o)
  );

  tzse_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .sample_i         (sample_i),
    .window_last_i    (window_last_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .word_i           (word_o),
    .word_valid_i     (word_valid_o),
    .window_end_i     (window_end_o),
    .trigger_found_i  (trigger_found_o),
    .trigger_offset_i (trigger_offset_o),
    .last_i           (last_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending_words)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: switches at random between four stall patterns
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_hold <= $urandom_range(50, 300);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RxOpen: begin
        out_ready_i <= 1'b1;
      end
      RxCoin: begin
        out_ready_i <= 1'($urandom_range(0, 1));
      end
      RxPeriodic: begin
        out_ready_i <= (rx_tick < 3'd5);
      end
      default: begin
        out_ready_i <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge where the sample was taken, or after an idle gap that follows it
  task automatic send_sample(input logic [SampleW-1:0] s, input logic closing);
    in_valid_i <= 1'b1;
    sample_i <= s;
    window_last_i <= closing;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (idle_on) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold the input until every predicted word has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  task automatic set_band(input int lo, input int hi);
    drain_results();
    // a sample with no output may still be in flight
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= RegWindowLow;
    cfg_wdata_i <= SampleW'(lo);
    @(posedge clk_i);
    cfg_index_i <= RegWindowHigh;
    cfg_wdata_i <= SampleW'(hi);
    @(posedge clk_i);
    // unmapped index, must not disturb anything
    cfg_index_i <= $urandom_range(0, 1) ? RegSpare2 : RegSpare3;
    cfg_wdata_i <= SampleW'($urandom_range(0, SampleMax));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    band_lo = lo;
    band_hi = hi;
  endtask

  function automatic logic [SampleW-1:0] pick_sample(input int keep_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      case ($urandom_range(0, 5))
        0: return '0;
        1: return SampleW'(SampleMax);
        2: return SampleW'(band_lo);
        3: return SampleW'(band_hi);
        4: return SampleW'((band_lo > 0) ? band_lo - 1 : 0);
        default: return SampleW'((band_hi < SampleMax) ? band_hi + 1 : SampleMax);
      endcase
    end
    if (r < 15) begin
      return SampleW'($urandom_range(0, SampleMax));
    end
    if ($urandom_range(0, 99) < keep_pct) begin
      if (band_lo > 0 && (band_hi >= SampleMax || $urandom_range(0, 1) == 1)) begin
        return SampleW'($urandom_range(0, band_lo - 1));
      end
      if (band_hi < SampleMax) begin
        return SampleW'($urandom_range(band_hi + 1, SampleMax));
      end
    end
    if (band_lo <= band_hi) begin
      return SampleW'($urandom_range(band_lo, band_hi));
    end
    return SampleW'($urandom_range(0, SampleMax));
  endfunction

  initial begin
    int lo;
    int hi;
    int done;
    int wlen;
    int keep_pct;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset thresholds 65..959 in band
    send_sample(15'd100, 1'b0);    // dropped before first keep
    send_sample(15'd0, 1'b0);      // first keep at offset 1
    send_sample(15'd500, 1'b0);
    send_sample(15'd500, 1'b0);
    send_sample(15'd500, 1'b0);
    send_sample(15'd32767, 1'b0);  // skip word of 3, then sample
    send_sample(15'd64, 1'b0);     // just below low edge
    send_sample(15'd65, 1'b0);
    send_sample(15'd959, 1'b0);
    send_sample(15'd960, 1'b0);    // just above high edge
    send_sample(15'd200, 1'b1);    // trailing run dropped, bare end
    send_sample(15'd1000, 1'b1);   // one-sample window, kept
    send_sample(15'd10, 1'b0);
    send_sample(15'd500, 1'b0);
    send_sample(15'd5, 1'b1);      // skip then sample carrying the end
    send_sample(15'd500, 1'b1);    // bare end, nothing kept
    // crossed band keeps everything
    set_band(1000, 200);
    send_sample(15'd500, 1'b0);
    send_sample(15'd0, 1'b0);
    send_sample(15'd32767, 1'b1);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin lo = 65;       hi = 959;       end
        1: begin lo = 0;        hi = SampleMax; end
        2: begin lo = SampleMax; hi = 0;        end
        3: begin lo = 0;        hi = 0;         end
        4: begin lo = SampleMax; hi = SampleMax; end
        default: begin
          lo = $urandom_range(0, 16000);
          hi = lo + $urandom_range(0, SampleMax - lo);
        end
      endcase
      set_band(lo, hi);
      idle_on = (p % 3 != 2);
      done = 0;
      while (done < PhaseItems) begin
        wlen = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 24);
        keep_pct = $urandom_range(0, 100);
        for (int k = 0; k < wlen; k++) begin
          send_sample(pick_sample(keep_pct), k == wlen - 1);
        end
        done += wlen;
        if ($urandom_range(0, 15) == 0) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_words == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
